// File: hw/rtl/pai_pkg.sv
// Shared types and constants for the positional array insert/delete/search unit.
`timescale 1ns / 1ps
`default_nettype none

package pai_pkg;

   localparam int POS_W   = 7;
   localparam int VAL_W   = 32;
   localparam int FOUND_W = 6;
   localparam int LIVE_W  = 7;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BADPOS   = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_SCAN = 1'b1
   } ctl_state_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_INSERT = 3'd1,
      CELL_DELETE = 3'd2,
      CELL_MATCH  = 3'd3,
      CELL_SHIFT  = 3'd4
   } cell_op_type;

   typedef struct packed {
      cmd_type                  command;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [FOUND_W-1:0]       found_index;
      logic [LIVE_W-1:0]        live_count;
   } rsp_type;

   // Broadcast from the controller to every cell of the row.
   typedef struct packed {
      cell_op_type              op;
      logic [POS_W-1:0]         position;
      logic [VAL_W-1:0]         value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: hw/rtl/pai_cell.sv
// One storage cell of the array row: holds an entry and a match flag.
`timescale 1ns / 1ps
`default_nettype none

module pai_cell #(
   parameter int CNT_W      = 7,
   parameter int CMP_W      = 7,
   parameter int CELL_INDEX = 0
) (
   input  wire                              clock,
   input  pai_pkg::cell_ctrl_type           cell_ctrl,
   input  wire  [CNT_W-1:0]                 count,
   input  wire  [pai_pkg::VAL_W-1:0]        left_data,
   input  wire  [pai_pkg::VAL_W-1:0]        right_data,
   input  wire                              right_match,
   output logic [pai_pkg::VAL_W-1:0]        data_out,
   output logic                             match_out
);

   localparam logic [CMP_W-1:0] MyIdx = CMP_W'(CELL_INDEX);

   logic [pai_pkg::VAL_W-1:0] data_ff;
   logic [pai_pkg::VAL_W-1:0] data_in;
   logic                      match_ff;
   logic                      match_in;
   logic [CMP_W-1:0]          pos_ext;
   logic [CMP_W-1:0]          cnt_ext;

   assign pos_ext = CMP_W'(cell_ctrl.position);
   assign cnt_ext = CMP_W'(count);

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      unique case (cell_ctrl.op)
         pai_pkg::CELL_HOLD: begin
         end
         pai_pkg::CELL_INSERT: begin
            // cells above the slot take their lower neighbor
            if (MyIdx > pos_ext) begin
               data_in = left_data;
            end else if (MyIdx == pos_ext) begin
               data_in = cell_ctrl.value;
            end
         end
         pai_pkg::CELL_DELETE: begin
            if (MyIdx >= pos_ext) begin
               data_in = right_data;
            end
         end
         pai_pkg::CELL_MATCH: begin
            match_in = (MyIdx < cnt_ext) && (data_ff == cell_ctrl.value);
         end
         pai_pkg::CELL_SHIFT: begin
            // advance flags toward cell 0 for the scan
            match_in = right_match;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data_out  = data_ff;
   assign match_out = match_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pai_ctrl.sv
// Command controller: entry count, search scan sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

module pai_ctrl #(
   parameter int DEPTH = 64,
   parameter int CNT_W = 7,
   parameter int IDX_W = 6,
   parameter int CMP_W = 7
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  pai_pkg::req_type         req_payload,
   output logic                     rsp_strobe,
   output pai_pkg::rsp_type         rsp_payload,
   output pai_pkg::cell_ctrl_type   cell_ctrl,
   output logic [CNT_W-1:0]         count,
   input  wire                      head_match
);

   pai_pkg::ctl_state_type state_ff;
   pai_pkg::ctl_state_type state_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [IDX_W-1:0]       idx_ff;
   logic [IDX_W-1:0]       idx_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   pai_pkg::rsp_type       rsp_ff;
   pai_pkg::rsp_type       rsp_in;
   logic                   accept;
   logic [CMP_W-1:0]       pos_ext;
   logic [CMP_W-1:0]       cnt_ext;
   logic                   scan_last;

   assign busy      = (state_ff == pai_pkg::CTL_SCAN);
   assign accept    = start && !busy;
   assign pos_ext   = CMP_W'(req_payload.position);
   assign cnt_ext   = CMP_W'(count_ff);
   assign scan_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pai_pkg::CTL_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      idx_in             = idx_ff;
      rsp_valid_in       = 1'b0;
      rsp_in             = rsp_ff;
      cell_ctrl.op       = pai_pkg::CELL_HOLD;
      cell_ctrl.position = req_payload.position;
      cell_ctrl.value    = req_payload.value;
      unique case (state_ff)
         pai_pkg::CTL_IDLE: begin
            if (accept) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = pai_pkg::ST_OK;
               rsp_in.found_index = '0;
               unique case (req_payload.command)
                  pai_pkg::CMD_INSERT: begin
                     if (pos_ext > cnt_ext) begin
                        rsp_in.status = pai_pkg::ST_BADPOS;
                     end else if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_in.status = pai_pkg::ST_FULL;
                     end else begin
                        cell_ctrl.op = pai_pkg::CELL_INSERT;
                        count_in     = count_ff + CNT_W'(1);
                     end
                  end
                  pai_pkg::CMD_DELETE: begin
                     if (pos_ext >= cnt_ext) begin
                        rsp_in.status = pai_pkg::ST_BADPOS;
                     end else begin
                        cell_ctrl.op = pai_pkg::CELL_DELETE;
                        count_in     = count_ff - CNT_W'(1);
                     end
                  end
                  pai_pkg::CMD_SEARCH: begin
                     cell_ctrl.op = pai_pkg::CELL_MATCH;
                     if (count_ff == '0) begin
                        rsp_in.status = pai_pkg::ST_NOTFOUND;
                     end else begin
                        // hold the result until the scan ends
                        rsp_valid_in = 1'b0;
                        idx_in       = '0;
                        state_in     = pai_pkg::CTL_SCAN;
                     end
                  end
                  pai_pkg::CMD_NOP: begin
                  end
                  default: begin
                  end
               endcase
               rsp_in.live_count = pai_pkg::LIVE_W'(count_in);
            end
         end
         pai_pkg::CTL_SCAN: begin
            if (head_match) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = pai_pkg::ST_OK;
               rsp_in.found_index = pai_pkg::FOUND_W'(idx_ff);
               rsp_in.live_count  = pai_pkg::LIVE_W'(count_ff);
               state_in           = pai_pkg::CTL_IDLE;
            end else if (scan_last) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = pai_pkg::ST_NOTFOUND;
               rsp_in.found_index = '0;
               rsp_in.live_count  = pai_pkg::LIVE_W'(count_ff);
               state_in           = pai_pkg::CTL_IDLE;
            end else begin
               cell_ctrl.op = pai_pkg::CELL_SHIFT;
               idx_in       = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = pai_pkg::CTL_IDLE;
         end
      endcase
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign count       = count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_count_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without a command transfer");

   a_quick_cmd_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.command != pai_pkg::CMD_SEARCH) |=> rsp_valid_ff)
      else $error("missing result for insert, delete or unused command");

   a_scan_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (busy && !head_match && !scan_last) |=> (!rsp_valid_ff && busy))
      else $error("scan ended early");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == pai_pkg::ST_FULL) |-> count_ff == CNT_W'(DEPTH))
      else $error("full status while array not full");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/positional_array_insert_delete_search_unit.sv
// Top level: positional array with insert, delete and linear search over a row of cells.
`timescale 1ns / 1ps
`default_nettype none

// Keeps an ordered array of up to DEPTH signed 32-bit entries in a row of register cells,
// each cell holding one entry and trading data with its neighbors. A command is taken at
// a clock edge where start is high and busy is low, and gives exactly one result, shown
// for one cycle with rsp_strobe high; results cannot be held off. An accepted insert or
// delete rewrites the cells from the given position upward in the transfer cycle; these and
// the unused command keep busy low and show their result in the next cycle, so one such
// command can be taken every cycle. Search latches a match flag in every cell, then walks
// the flags down the row one cell per cycle toward cell 0: busy stays high until the flag
// of the lowest match reaches cell 0, or on a miss until every live cell is scanned, and
// the result shows in the cycle in which busy falls, in which the next command may already
// be taken. A search of an empty array answers in the next cycle without a scan.
module positional_array_insert_delete_search_unit #(
   parameter int DEPTH = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  pai_pkg::req_type        req_payload,
   output logic                    rsp_strobe,
   output pai_pkg::rsp_type        rsp_payload
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam int IdxW = $clog2(DEPTH);
   localparam int CmpW = (CntW > pai_pkg::POS_W) ? CntW : pai_pkg::POS_W;

   pai_pkg::cell_ctrl_type     cell_ctrl;
   logic [CntW-1:0]            count;
   logic [pai_pkg::VAL_W-1:0]  data_bus  [DEPTH];
   logic                       match_bus [DEPTH];

   pai_ctrl #(
      .DEPTH (DEPTH),
      .CNT_W (CntW),
      .IDX_W (IdxW),
      .CMP_W (CmpW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .cell_ctrl   (cell_ctrl),
      .count       (count),
      .head_match  (match_bus[0])
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [pai_pkg::VAL_W-1:0] left_data;
      logic [pai_pkg::VAL_W-1:0] right_data;
      logic                      right_match;

      if (i == 0) begin : g_first
         assign left_data = cell_ctrl.value;
      end else begin : g_inner_l
         assign left_data = data_bus[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data  = data_bus[i];
         assign right_match = 1'b0;
      end else begin : g_inner_r
         assign right_data  = data_bus[i+1];
         assign right_match = match_bus[i+1];
      end

      pai_cell #(
         .CNT_W      (CntW),
         .CMP_W      (CmpW),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cell_ctrl   (cell_ctrl),
         .count       (count),
         .left_data   (left_data),
         .right_data  (right_data),
         .right_match (right_match),
         .data_out    (data_bus[i]),
         .match_out   (match_bus[i])
      );
   end

endmodule

`default_nettype wire
